### sv/eba_pkg.sv
// ----------------------------------------------------------------------------
// eba_pkg
// shared types, opcode codes and stack index helpers for the 8-bit alu core
// ----------------------------------------------------------------------------
package eba_pkg;

  localparam int STACK_DEPTH = 256;

  // opcode groups (upper nibble)
  localparam logic [3:0] OPG_FLAG  = 4'h0;
  localparam logic [3:0] OPG_ROT   = 4'h1;
  localparam logic [3:0] OPG_INC   = 4'h2;
  localparam logic [3:0] OPG_STACK = 4'h3;
  localparam logic [3:0] OPG_MOVE  = 4'h6;
  localparam logic [3:0] OPG_ADD   = 4'h8;
  localparam logic [3:0] OPG_SUB   = 4'h9;
  localparam logic [3:0] OPG_PUSH  = 4'hB;
  localparam logic [3:0] OPG_SETZ  = 4'hD;

  // full opcodes
  localparam logic [7:0] OP_CLC  = 8'h05;
  localparam logic [7:0] OP_CLN  = 8'h06;
  localparam logic [7:0] OP_CLZ  = 8'h07;
  localparam logic [7:0] OP_CLV  = 8'h08;
  localparam logic [7:0] OP_SEZ0 = 8'hD0;
  localparam logic [7:0] OP_SEZ1 = 8'hD5;
  localparam logic [7:0] OP_SEZ2 = 8'hDA;
  localparam logic [7:0] OP_SEZ3 = 8'hDF;

  // low two bits within a group
  localparam logic [1:0] SUB_ROL = 2'd0;
  localparam logic [1:0] SUB_ROR = 2'd1;
  localparam logic [1:0] SUB_ADI = 2'd2;
  localparam logic [1:0] SUB_SBI = 2'd3;
  localparam logic [1:0] SUB_INC = 2'd0;
  localparam logic [1:0] SUB_DEC = 2'd1;
  localparam logic [1:0] SUB_POP = 2'd0;
  localparam logic [1:0] SUB_TOP = 2'd1;

  // flag bit positions
  localparam int FLAG_Z = 0;
  localparam int FLAG_N = 1;
  localparam int FLAG_C = 2;
  localparam int FLAG_V = 3;

  typedef struct packed {
    logic [3:0][7:0] gpr;
    logic [3:0]      flags;
    logic [7:0]      sp;
  } arch_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } stk_wr_t;

  // stack index tracks sp modulo depth
  function automatic logic [7:0] idx_inc(input logic [7:0] sp, input logic [7:0] idx,
                                         input logic [7:0] last);
    logic [7:0] r;
    if (sp == 8'hFF || idx == last) r = 8'd0;
    else r = idx + 8'd1;
    return r;
  endfunction

  function automatic logic [7:0] idx_dec(input logic [7:0] sp, input logic [7:0] idx,
                                         input logic [7:0] last, input logic [7:0] wrap);
    logic [7:0] r;
    if (sp == 8'h00) r = wrap;
    else if (idx == 8'd0) r = last;
    else r = idx - 8'd1;
    return r;
  endfunction

endpackage

### sv/eba_ram.sv
// ----------------------------------------------------------------------------
// eba_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module eba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/eba_exec.sv
// ----------------------------------------------------------------------------
// eba_exec
// single pass instruction execute: next register, flag and stack state
// ----------------------------------------------------------------------------
module eba_exec #(
  parameter int STACK_DEPTH = eba_pkg::STACK_DEPTH
) (
  input  logic [7:0]                     opcode,
  input  logic [7:0]                     imm,
  input  eba_pkg::arch_t                 cur,
  input  logic [$clog2(STACK_DEPTH)-1:0] idx,
  input  logic [7:0]                     stk_data,
  output eba_pkg::arch_t                 nxt,
  output logic [$clog2(STACK_DEPTH)-1:0] idx_nxt,
  output eba_pkg::stk_wr_t               stk_wr
);

  localparam int         IDX_W    = $clog2(STACK_DEPTH);
  localparam logic [7:0] IDX_LAST = 8'(STACK_DEPTH - 1);
  localparam logic [7:0] IDX_WRAP = 8'(255 % STACK_DEPTH);

  logic [3:0] hi;
  logic [1:0] lo2;
  logic [1:0] mid2;
  logic [7:0] sel;
  logic [7:0] src;
  logic [7:0] res;
  logic [7:0] idx8;
  logic [7:0] idx8_nxt;

  assign hi   = opcode[7:4];
  assign lo2  = opcode[1:0];
  assign mid2 = opcode[3:2];
  assign sel  = cur.gpr[mid2];
  assign src  = cur.gpr[lo2];
  assign idx8 = 8'(idx);
  assign res  = (hi == eba_pkg::OPG_ADD) ? sel + src : sel - src;

  always_comb begin
    nxt      = cur;
    idx8_nxt = idx8;
    stk_wr   = '0;
    case (hi)
      eba_pkg::OPG_FLAG: begin
        case (opcode)
          eba_pkg::OP_CLC: nxt.flags[eba_pkg::FLAG_C] = 1'b0;
          eba_pkg::OP_CLN: nxt.flags[eba_pkg::FLAG_N] = 1'b0;
          eba_pkg::OP_CLZ: nxt.flags[eba_pkg::FLAG_Z] = 1'b0;
          eba_pkg::OP_CLV: nxt.flags[eba_pkg::FLAG_V] = 1'b0;
          default: ;
        endcase
      end
      eba_pkg::OPG_ROT: begin
        case (lo2)
          eba_pkg::SUB_ROL: nxt.gpr[mid2] = {sel[6:0], sel[7]};
          eba_pkg::SUB_ROR: nxt.gpr[mid2] = {sel[0], sel[7:1]};
          eba_pkg::SUB_ADI: nxt.gpr[mid2] = sel + imm;
          default:          nxt.gpr[mid2] = sel - imm;
        endcase
      end
      eba_pkg::OPG_INC: begin
        if (lo2 == eba_pkg::SUB_INC) begin
          nxt.gpr[mid2] = sel + 8'd1;
        end else if (lo2 == eba_pkg::SUB_DEC) begin
          nxt.gpr[mid2] = sel - 8'd1;
        end
      end
      eba_pkg::OPG_STACK: begin
        if (lo2 == eba_pkg::SUB_POP) begin
          nxt.sp        = cur.sp - 8'd1;
          idx8_nxt      = eba_pkg::idx_dec(cur.sp, idx8, IDX_LAST, IDX_WRAP);
          nxt.gpr[mid2] = stk_data;
        end else if (lo2 == eba_pkg::SUB_TOP) begin
          nxt.gpr[mid2] = stk_data;
        end
      end
      eba_pkg::OPG_MOVE: begin
        if (lo2 != mid2) begin
          nxt.gpr[lo2] = sel;
        end
      end
      eba_pkg::OPG_ADD, eba_pkg::OPG_SUB: begin
        nxt.gpr[mid2]               = res;
        nxt.flags[eba_pkg::FLAG_Z] = (res == 8'd0);
        nxt.flags[eba_pkg::FLAG_N] = (res != 8'd0);
      end
      eba_pkg::OPG_PUSH: begin
        if (mid2 == 2'd0) begin
          stk_wr.en   = 1'b1;
          stk_wr.data = src;
          nxt.sp      = cur.sp + 8'd1;
          idx8_nxt    = eba_pkg::idx_inc(cur.sp, idx8, IDX_LAST);
        end
      end
      eba_pkg::OPG_SETZ: begin
        if (opcode == eba_pkg::OP_SEZ0 || opcode == eba_pkg::OP_SEZ1 ||
            opcode == eba_pkg::OP_SEZ2 || opcode == eba_pkg::OP_SEZ3) begin
          nxt.flags[eba_pkg::FLAG_Z] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign idx_nxt = idx8_nxt[IDX_W-1:0];

endmodule

### sv/eight_bit_register_alu_execute_core.sv
// ----------------------------------------------------------------------------
// eight_bit_register_alu_execute_core
// 8-bit register alu execute stage with four registers, flags and a stack
// ----------------------------------------------------------------------------
// usage
//   in channel: in_opcode and in_immediate_byte, valid/ready handshake
//   out channel: registers a, b, x, y, flags and stack pointer after each item
//   flow: an accepted item waits in the input register and executes into the
//     result registers once the output side is free; its result is then valid
//   throughput: one item per cycle while out_ready stays high, set by the single
//     execute stage and the one stack ram read started when an item is accepted
//   stack: ram of STACK_DEPTH bytes, a push of the previous item is forwarded
//     to a pop that follows it directly
//   reset: registers, flags and pointer go to zero, the stack reads as zero
//     until written (per-entry valid bits), no clearing pass
//   stall: while out_ready is low the result holds, one more item waits in
//     the input register, then in_ready drops
// ----------------------------------------------------------------------------
module eight_bit_register_alu_execute_core #(
  parameter int STACK_DEPTH = eba_pkg::STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_opcode,
  input  logic [7:0] in_immediate_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_acc_a,
  output logic [7:0] out_acc_b,
  output logic [7:0] out_index_x,
  output logic [7:0] out_index_y,
  output logic [3:0] out_status_flags,
  output logic [7:0] out_stack_level
);

  localparam int         IDX_W    = $clog2(STACK_DEPTH);
  localparam logic [7:0] IDX_LAST = 8'(STACK_DEPTH - 1);
  localparam logic [7:0] IDX_WRAP = 8'(255 % STACK_DEPTH);

  logic                   s1_vld_r;
  logic [7:0]             op_r;
  logic [7:0]             imm_r;
  logic                   out_vld_r;
  eba_pkg::arch_t         arch_r;
  eba_pkg::arch_t         arch_nxt;
  eba_pkg::arch_t         base;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       idx_nxt;
  logic [IDX_W-1:0]       base_idx;
  logic [STACK_DEPTH-1:0] ent_vld_r;
  logic                   fwd_r;
  logic [7:0]             fwd_data_r;
  logic                   rd_vld_r;
  eba_pkg::stk_wr_t       stk_wr;
  logic                   exec_fire;
  logic                   in_fire;
  logic [7:0]             rd_idx8;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_hit;
  logic [7:0]             ram_rdata;
  logic [7:0]             stk_data;

  assign exec_fire = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || exec_fire;
  assign in_fire   = in_valid && in_ready;

  // read address for the incoming item, from the state the previous one leaves
  assign base     = exec_fire ? arch_nxt : arch_r;
  assign base_idx = exec_fire ? idx_nxt : idx_r;
  assign rd_idx8  = (in_opcode[7:4] == eba_pkg::OPG_STACK &&
                     in_opcode[1:0] == eba_pkg::SUB_POP) ?
                    eba_pkg::idx_dec(base.sp, 8'(base_idx), IDX_LAST, IDX_WRAP) :
                    8'(base_idx);
  assign rd_addr  = rd_idx8[IDX_W-1:0];
  assign wr_hit   = exec_fire && stk_wr.en && (idx_r == rd_addr);

  assign stk_data = fwd_r ? fwd_data_r : (rd_vld_r ? ram_rdata : 8'd0);

  eba_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (exec_fire && stk_wr.en),
    .wr_addr (idx_r),
    .wr_data (stk_wr.data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  eba_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .opcode   (op_r),
    .imm      (imm_r),
    .cur      (arch_r),
    .idx      (idx_r),
    .stk_data (stk_data),
    .nxt      (arch_nxt),
    .idx_nxt  (idx_nxt),
    .stk_wr   (stk_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      arch_r    <= '0;
      idx_r     <= '0;
      ent_vld_r <= '0;
      fwd_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
        fwd_r    <= wr_hit;
        rd_vld_r <= ent_vld_r[rd_addr];
      end else if (exec_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (exec_fire) begin
        out_vld_r <= 1'b1;
        arch_r    <= arch_nxt;
        idx_r     <= idx_nxt;
        if (stk_wr.en) begin
          ent_vld_r[idx_r] <= 1'b1;
        end
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_opcode;
      imm_r      <= in_immediate_byte;
      fwd_data_r <= stk_wr.data;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_acc_a        = arch_r.gpr[0];
  assign out_acc_b        = arch_r.gpr[1];
  assign out_index_x      = arch_r.gpr[2];
  assign out_index_y      = arch_r.gpr[3];
  assign out_status_flags = arch_r.flags;
  assign out_stack_level  = arch_r.sp;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 8-bit register alu execute core: a directed
// opener over every instruction group, then random items with push and pop
// runs, checked item by item against an in-bench model of the registers,
// flags and stack, with bursty input and a stalling result side
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] imm;
  } insn_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] flags;
    logic [7:0] sp;
  } arch_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_opcode = 8'h00;
  logic [7:0] in_immediate_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_acc_a;
  logic [7:0] out_acc_b;
  logic [7:0] out_index_x;
  logic [7:0] out_index_y;
  logic [3:0] out_status_flags;
  logic [7:0] out_stack_level;

  eight_bit_register_alu_execute_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_immediate_byte(in_immediate_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_acc_a        (out_acc_a),
    .out_acc_b        (out_acc_b),
    .out_index_x      (out_index_x),
    .out_index_y      (out_index_y),
    .out_status_flags (out_status_flags),
    .out_stack_level  (out_stack_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [7:0] gpr_mdl [4];
  logic [3:0] flags_mdl;
  logic [7:0] sp_mdl;
  logic [7:0] stack_mdl [eba_pkg::STACK_DEPTH];

  insn_t      pending_insns[$];
  arch_view_t expected_views[$];
  int         err_cnt = 0;

  task automatic add_insn(input logic [7:0] op, input logic [7:0] imm);
    insn_t t;
    t.op = op;
    t.imm = imm;
    pending_insns.push_back(t);
  endtask

  function automatic logic [7:0] pick_imm();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_opcode();
    int         sel;
    logic [1:0] r;
    logic [1:0] s;
    sel = $urandom_range(0, 99);
    r = 2'($urandom_range(0, 3));
    s = 2'($urandom_range(0, 3));
    if (sel < 12) return 8'($urandom_range(0, 255));
    if (sel < 16) begin
      case (s)
        2'd0: return eba_pkg::OP_CLC;
        2'd1: return eba_pkg::OP_CLN;
        2'd2: return eba_pkg::OP_CLZ;
        default: return eba_pkg::OP_CLV;
      endcase
    end
    if (sel < 20) begin
      case (s)
        2'd0: return eba_pkg::OP_SEZ0;
        2'd1: return eba_pkg::OP_SEZ1;
        2'd2: return eba_pkg::OP_SEZ2;
        default: return eba_pkg::OP_SEZ3;
      endcase
    end
    if (sel < 38) return {eba_pkg::OPG_ROT, r, s};
    if (sel < 48) return {eba_pkg::OPG_INC, r, 1'b0, s[0]};
    if (sel < 60) return {eba_pkg::OPG_MOVE, r, s};
    if (sel < 70) return {eba_pkg::OPG_ADD, r, s};
    if (sel < 80) return {eba_pkg::OPG_SUB, r, s};
    if (sel < 90) return {eba_pkg::OPG_PUSH, 2'b00, s};
    return {eba_pkg::OPG_STACK, r, 1'b0, s[0]};
  endfunction

  // executes one item on the model and queues the register view it leaves
  task automatic execute_insn(input logic [7:0] op, input logic [7:0] imm);
    logic [1:0] lo;
    logic [1:0] mid;
    logic [7:0] v;
    arch_view_t view;
    lo = op[1:0];
    mid = op[3:2];
    case (op[7:4])
      eba_pkg::OPG_FLAG: begin
        case (op)
          eba_pkg::OP_CLC: flags_mdl[eba_pkg::FLAG_C] = 1'b0;
          eba_pkg::OP_CLN: flags_mdl[eba_pkg::FLAG_N] = 1'b0;
          eba_pkg::OP_CLZ: flags_mdl[eba_pkg::FLAG_Z] = 1'b0;
          eba_pkg::OP_CLV: flags_mdl[eba_pkg::FLAG_V] = 1'b0;
          default: ;
        endcase
      end
      eba_pkg::OPG_ROT: begin
        v = gpr_mdl[mid];
        case (lo)
          eba_pkg::SUB_ROL: gpr_mdl[mid] = {v[6:0], v[7]};
          eba_pkg::SUB_ROR: gpr_mdl[mid] = {v[0], v[7:1]};
          eba_pkg::SUB_ADI: gpr_mdl[mid] = v + imm;
          default: gpr_mdl[mid] = v - imm;
        endcase
      end
      eba_pkg::OPG_INC: begin
        if (lo == eba_pkg::SUB_INC) gpr_mdl[mid] = gpr_mdl[mid] + 8'd1;
        else if (lo == eba_pkg::SUB_DEC) gpr_mdl[mid] = gpr_mdl[mid] - 8'd1;
      end
      eba_pkg::OPG_STACK: begin
        if (lo == eba_pkg::SUB_POP) begin
          sp_mdl = sp_mdl - 8'd1;
          gpr_mdl[mid] = stack_mdl[sp_mdl % eba_pkg::STACK_DEPTH];
        end else if (lo == eba_pkg::SUB_TOP) begin
          gpr_mdl[mid] = stack_mdl[sp_mdl % eba_pkg::STACK_DEPTH];
        end
      end
      eba_pkg::OPG_MOVE: begin
        if (lo != mid) gpr_mdl[lo] = gpr_mdl[mid];
      end
      eba_pkg::OPG_ADD, eba_pkg::OPG_SUB: begin
        if (op[7:4] == eba_pkg::OPG_ADD) v = gpr_mdl[mid] + gpr_mdl[lo];
        else v = gpr_mdl[mid] - gpr_mdl[lo];
        gpr_mdl[mid] = v;
        flags_mdl[eba_pkg::FLAG_Z] = (v == 8'd0);
        flags_mdl[eba_pkg::FLAG_N] = (v != 8'd0);
      end
      eba_pkg::OPG_PUSH: begin
        if (mid == 2'd0) begin
          stack_mdl[sp_mdl % eba_pkg::STACK_DEPTH] = gpr_mdl[lo];
          sp_mdl = sp_mdl + 8'd1;
        end
      end
      eba_pkg::OPG_SETZ: begin
        if (op == eba_pkg::OP_SEZ0 || op == eba_pkg::OP_SEZ1 ||
            op == eba_pkg::OP_SEZ2 || op == eba_pkg::OP_SEZ3)
          flags_mdl[eba_pkg::FLAG_Z] = 1'b1;
      end
      default: ;
    endcase
    view.a = gpr_mdl[0];
    view.b = gpr_mdl[1];
    view.x = gpr_mdl[2];
    view.y = gpr_mdl[3];
    view.flags = flags_mdl;
    view.sp = sp_mdl;
    expected_views.push_back(view);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      err_cnt++;
    end
  endtask

  // driver: bursts of items with random gaps
  insn_t next_insn;
  int    burst_left = 1;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_insns.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_insn = pending_insns.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_insn.op;
        in_immediate_byte <= next_insn.imm;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // receiver: out_ready from one of four stall modes, picked anew when a mode runs out
  int         mode_left = 0;
  int         stall_mode = 0;
  logic [7:0] stall_pat = 8'hFF;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
        stall_pat = 8'($urandom_range(0, 255));
      end
      mode_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= stall_pat[mode_left % 8];
      endcase
    end
  end

  // monitor: check results first, then model the item accepted at this edge
  arch_view_t got_view;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result item with no item outstanding");
          err_cnt++;
        end else begin
          got_view = expected_views.pop_front();
          check_field("acc_a", got_view.a, out_acc_a);
          check_field("acc_b", got_view.b, out_acc_b);
          check_field("index_x", got_view.x, out_index_x);
          check_field("index_y", got_view.y, out_index_y);
          check_field("status_flags", {4'h0, got_view.flags}, {4'h0, out_status_flags});
          check_field("stack_level", got_view.sp, out_stack_level);
        end
      end
      if (in_valid && in_ready) execute_insn(in_opcode, in_immediate_byte);
    end
  end

  initial begin
    int n;
    foreach (gpr_mdl[i]) gpr_mdl[i] = 8'h00;
    foreach (stack_mdl[i]) stack_mdl[i] = 8'h00;
    flags_mdl = 4'h0;
    sp_mdl = 8'h00;

    // directed opener
    add_insn(eba_pkg::OP_CLC, 8'h00);
    add_insn(eba_pkg::OP_CLN, 8'hFF);
    add_insn(eba_pkg::OP_CLZ, 8'h00);
    add_insn(eba_pkg::OP_CLV, 8'hFF);
    add_insn({eba_pkg::OPG_ROT, 2'd0, eba_pkg::SUB_ADI}, 8'hFF);
    add_insn({eba_pkg::OPG_ROT, 2'd1, eba_pkg::SUB_SBI}, 8'h01);
    add_insn({eba_pkg::OPG_ROT, 2'd0, eba_pkg::SUB_ROL}, 8'h00);
    add_insn({eba_pkg::OPG_ROT, 2'd1, eba_pkg::SUB_ROR}, 8'h00);
    add_insn({eba_pkg::OPG_ROT, 2'd2, eba_pkg::SUB_ADI}, 8'h80);
    add_insn({eba_pkg::OPG_INC, 2'd3, eba_pkg::SUB_INC}, 8'h00);
    add_insn({eba_pkg::OPG_INC, 2'd3, eba_pkg::SUB_DEC}, 8'h00);
    add_insn({eba_pkg::OPG_INC, 2'd3, eba_pkg::SUB_DEC}, 8'h00);
    add_insn({eba_pkg::OPG_MOVE, 2'd0, 2'd3}, 8'h00);
    add_insn({eba_pkg::OPG_ADD, 2'd0, 2'd1}, 8'h00);
    add_insn({eba_pkg::OPG_SUB, 2'd2, 2'd2}, 8'h00);
    add_insn(eba_pkg::OP_SEZ1, 8'h00);
    add_insn(eba_pkg::OP_CLZ, 8'h00);
    // pop from empty stack wraps the pointer down, the push wraps it back
    add_insn({eba_pkg::OPG_STACK, 2'd1, eba_pkg::SUB_POP}, 8'h00);
    add_insn({eba_pkg::OPG_PUSH, 2'd0, 2'd1}, 8'h00);
    add_insn({eba_pkg::OPG_STACK, 2'd0, eba_pkg::SUB_TOP}, 8'h00);
    add_insn({eba_pkg::OPG_PUSH, 2'd0, 2'd0}, 8'h00);
    add_insn({eba_pkg::OPG_STACK, 2'd3, eba_pkg::SUB_POP}, 8'h00);
    // undefined opcodes
    add_insn(8'h00, 8'hAA);
    add_insn(8'hFF, 8'h55);
    add_insn({eba_pkg::OPG_PUSH, 2'd1, 2'd0}, 8'hAA);
    add_insn({eba_pkg::OPG_INC, 2'd1, 2'd2}, 8'h55);

    // random part, with push runs followed by as many pop or top items
    while (pending_insns.size() < 545) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n)
          add_insn({eba_pkg::OPG_PUSH, 2'b00, 2'($urandom_range(0, 3))}, pick_imm());
        repeat ($urandom_range(0, 3)) add_insn(pick_opcode(), pick_imm());
        repeat (n)
          add_insn({eba_pkg::OPG_STACK, 2'($urandom_range(0, 3)), 1'b0,
                    1'($urandom_range(0, 1))}, pick_imm());
      end else begin
        add_insn(pick_opcode(), pick_imm());
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_insns.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule

### filelist.f
sv/eba_pkg.sv
sv/eba_ram.sv
sv/eba_exec.sv
sv/eight_bit_register_alu_execute_core.sv
dv/tb.sv
